### design/swlh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swlh_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 17;
  localparam int LEVEL_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int COLUMN_W = 10;
  localparam int CFG_W    = 11;

  // frame length after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // front to back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // one result beat
  typedef struct packed {
    logic        [COLUMN_W-1:0] column;
    logic        [LEVEL_W-1:0]  added_level;
    logic signed [COUNT_W-1:0]  added_count;
    logic        [LEVEL_W-1:0]  removed_level;
    logic signed [COUNT_W-1:0]  removed_count;
    logic                       last_in_frame;
  } out_beat_t;

endpackage

`default_nettype wire

### design/swlh_if.sv
`timescale 1ns / 1ps
`default_nettype none

// sample channel
interface swlh_in_if import swlh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// result channel
interface swlh_out_if import swlh_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [COLUMN_W-1:0] column;
  logic        [LEVEL_W-1:0]  added_level;
  logic signed [COUNT_W-1:0]  added_count;
  logic        [LEVEL_W-1:0]  removed_level;
  logic signed [COUNT_W-1:0]  removed_count;
  logic                       last_in_frame;

  modport source (output valid, output column, output added_level, output added_count,
                  output removed_level, output removed_count, output last_in_frame,
                  input ready);
  modport sink   (input valid, input column, input added_level, input added_count,
                  input removed_level, input removed_count, input last_in_frame,
                  output ready);
endinterface

`default_nettype wire

### design/swlh_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module swlh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports, read returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

### design/swlh_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module swlh_queue import swlh_pkg::*; #(
  parameter int WIDTH = 27
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [WIDTH-1:0]  push_data,
  input  wire logic              pop,
  output logic                   head_valid,
  output logic      [WIDTH-1:0]  head_data,
  output logic      [QCNT_W-1:0] count
);

  logic [WIDTH-1:0]  entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_valid = (count_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign count      = count_r;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

### design/swlh_front.sv
`timescale 1ns / 1ps
`default_nettype none

module swlh_front import swlh_pkg::*; #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int HISTORY_DEPTH = 256,
  parameter int COL_W         = 10,
  parameter int CLR_W         = 18
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_W-1:0]          cfg_wr_data,
  swlh_in_if.sink                        in_chan,
  input  wire logic                      clr_busy,
  input  wire logic [CLR_W-1:0]          clr_addr,
  input  wire logic [QCNT_W-1:0]         q_count,
  output logic                           q_push,
  output logic [COL_W+2*LEVEL_W:0]       q_data
);

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int HIST_AW = SLOT_W + COL_W;
  localparam int LEN_W   = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

  logic [CFG_W-1:0]   cols_r;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt, next_slot;
  logic               f1_valid_r;
  logic [COL_W-1:0]   f1_col_r;
  logic [LEVEL_W-1:0] f1_level_r;
  logic               f1_last_r;
  logic               in_fire;
  logic [24:0]        scaled;
  logic [LEVEL_W-1:0] level;
  logic [LEN_W-1:0]   cfg_ext, len;
  logic               last;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  logic [LEVEL_W-1:0] hist_wdata;
  logic [LEVEL_W-1:0] hist_rdata;

  // accept while the queue has room for this beat and the one in flight
  assign in_chan.ready = !clr_busy &&
    ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(f1_valid_r) < (QCNT_W+1)'(QUEUE_DEPTH));
  assign in_fire = in_chan.valid && in_chan.ready;

  // quantize: floor(sample * 255 / 65536), saturated
  always_comb begin
    scaled = {in_chan.sample, 8'd0} - 25'(in_chan.sample);
    level  = scaled[24] ? {LEVEL_W{1'b1}} : scaled[23:16];
  end

  // effective frame length and end of frame
  always_comb begin
    cfg_ext = LEN_W'(cols_r);
    priority if (cfg_ext == '0) begin
      len = LEN_W'(1);
    end else if (cfg_ext > LEN_W'(MAX_COLUMNS)) begin
      len = LEN_W'(MAX_COLUMNS);
    end else begin
      len = cfg_ext;
    end
    last = (LEN_W'(col_r) + LEN_W'(1) >= len);
  end

  // column and slot counters
  always_comb begin
    next_slot = (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
    col_nxt   = col_r;
    slot_nxt  = slot_r;
    if (in_fire) begin
      if (last) begin
        col_nxt  = '0;
        slot_nxt = next_slot;
      end else begin
        col_nxt  = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r     <= CFG_RESET;
      col_r      <= '0;
      slot_r     <= '0;
      f1_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cols_r <= cfg_wr_data;
      end
      col_r      <= col_nxt;
      slot_r     <= slot_nxt;
      f1_valid_r <= in_fire;
    end
  end

  // beat held while the history read completes
  always_ff @(posedge clk) begin
    if (in_fire) begin
      f1_col_r   <= col_r;
      f1_level_r <= level;
      f1_last_r  <= last;
    end
  end

  // history ring: write this slot, read the slot leaving the window
  always_comb begin
    hist_we    = clr_busy || in_fire;
    hist_waddr = clr_busy ? clr_addr[HIST_AW-1:0] : {slot_r, col_r};
    hist_wdata = clr_busy ? '0 : level;
  end

  swlh_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (1 << HIST_AW)
  ) u_hist_ram (
    .clk    (clk),
    .we     (hist_we),
    .waddr  (hist_waddr),
    .wdata  (hist_wdata),
    .re     (in_fire),
    .raddr0 ({next_slot, col_r}),
    .raddr1 ({next_slot, col_r}),
    .rdata0 (hist_rdata),
    .rdata1 ()
  );

  // hand the classified beat to the back end
  assign q_push = f1_valid_r;
  assign q_data = {f1_last_r, hist_rdata, f1_level_r, f1_col_r};

endmodule

`default_nettype wire

### design/swlh_back.sv
`timescale 1ns / 1ps
`default_nettype none

module swlh_back import swlh_pkg::*; #(
  parameter int COL_W = 10,
  parameter int CLR_W = 18
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      clr_busy,
  input  wire logic [CLR_W-1:0]          clr_addr,
  input  wire logic                      q_valid,
  input  wire logic [COL_W+2*LEVEL_W:0]  q_data,
  output logic                           q_pop,
  swlh_out_if.source                     out_chan
);

  localparam int CNT_AW = LEVEL_W + COL_W;

  logic [COL_W-1:0]   q_col;
  logic [LEVEL_W-1:0] q_add, q_rem;
  logic               q_last;

  logic               b2_valid_r;
  logic [COL_W-1:0]   b2_col_r;
  logic [LEVEL_W-1:0] b2_add_r, b2_rem_r;
  logic               b2_last_r;
  logic [CNT_AW-1:0]  addr_a, addr_r;

  logic [COUNT_W-1:0] inc_rd_a, inc_rd_r, dec_rd_a, dec_rd_r;
  logic [COUNT_W-1:0] inc_a, inc_r, dec_a, dec_r;
  logic [COUNT_W-1:0] inc_a_new, dec_r_new, dec_a_fin, inc_r_fin;
  logic               same;

  logic               inc_lw_v_r, dec_lw_v_r;
  logic [CNT_AW-1:0]  inc_lw_addr_r, dec_lw_addr_r;
  logic [COUNT_W-1:0] inc_lw_data_r, dec_lw_data_r;

  logic               cnt_we;
  logic [CNT_AW-1:0]  inc_waddr, dec_waddr;
  logic [COUNT_W-1:0] inc_wdata, dec_wdata;

  out_beat_t          beat;
  out_beat_t          ob_r [2];
  logic               ob_wr_r, ob_rd_r;
  logic [1:0]         ob_cnt_r, ob_cnt_nxt;
  logic               o_fire;

  assign {q_last, q_rem, q_add, q_col} = q_data;

  // pop only when the output buffer will still have room once the popped beat reaches it
  assign o_fire = out_chan.valid && out_chan.ready;
  assign q_pop  = q_valid &&
    (3'(ob_cnt_r) + 3'(b2_valid_r) <= 3'd1 + 3'(o_fire));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else begin
      b2_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_col_r  <= q_col;
      b2_add_r  <= q_add;
      b2_rem_r  <= q_rem;
      b2_last_r <= q_last;
    end
  end

  assign addr_a = {b2_add_r, b2_col_r};
  assign addr_r = {b2_rem_r, b2_col_r};

  // counts are kept as increments minus decrements, one write each per beat
  swlh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (1 << CNT_AW)
  ) u_inc_ram (
    .clk    (clk),
    .we     (cnt_we),
    .waddr  (inc_waddr),
    .wdata  (inc_wdata),
    .re     (q_pop),
    .raddr0 ({q_add, q_col}),
    .raddr1 ({q_rem, q_col}),
    .rdata0 (inc_rd_a),
    .rdata1 (inc_rd_r)
  );

  swlh_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (1 << CNT_AW)
  ) u_dec_ram (
    .clk    (clk),
    .we     (cnt_we),
    .waddr  (dec_waddr),
    .wdata  (dec_wdata),
    .re     (q_pop),
    .raddr0 ({q_add, q_col}),
    .raddr1 ({q_rem, q_col}),
    .rdata0 (dec_rd_a),
    .rdata1 (dec_rd_r)
  );

  // forward the latest write, which may land on the edge of the read
  always_comb begin
    inc_a = (inc_lw_v_r && inc_lw_addr_r == addr_a) ? inc_lw_data_r : inc_rd_a;
    inc_r = (inc_lw_v_r && inc_lw_addr_r == addr_r) ? inc_lw_data_r : inc_rd_r;
    dec_a = (dec_lw_v_r && dec_lw_addr_r == addr_a) ? dec_lw_data_r : dec_rd_a;
    dec_r = (dec_lw_v_r && dec_lw_addr_r == addr_r) ? dec_lw_data_r : dec_rd_r;
  end

  // update and net counts, increment first then decrement
  always_comb begin
    same      = (b2_add_r == b2_rem_r);
    inc_a_new = inc_a + 1'b1;
    dec_r_new = dec_r + 1'b1;
    dec_a_fin = same ? dec_r_new : dec_a;
    inc_r_fin = same ? inc_a_new : inc_r;
  end

  // memory writes, zero sweep after reset
  always_comb begin
    cnt_we    = clr_busy || b2_valid_r;
    inc_waddr = clr_busy ? clr_addr[CNT_AW-1:0] : addr_a;
    dec_waddr = clr_busy ? clr_addr[CNT_AW-1:0] : addr_r;
    inc_wdata = clr_busy ? '0 : inc_a_new;
    dec_wdata = clr_busy ? '0 : dec_r_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_lw_v_r <= 1'b0;
      dec_lw_v_r <= 1'b0;
    end else if (b2_valid_r) begin
      inc_lw_v_r <= 1'b1;
      dec_lw_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_valid_r) begin
      inc_lw_addr_r <= addr_a;
      inc_lw_data_r <= inc_a_new;
      dec_lw_addr_r <= addr_r;
      dec_lw_data_r <= dec_r_new;
    end
  end

  // result beat
  always_comb begin
    beat.column        = COLUMN_W'(b2_col_r);
    beat.added_level   = b2_add_r;
    beat.added_count   = $signed(inc_a_new - dec_a_fin);
    beat.removed_level = b2_rem_r;
    beat.removed_count = $signed(inc_r_fin - dec_r_new);
    beat.last_in_frame = b2_last_r;
  end

  // two-entry output buffer
  assign ob_cnt_nxt = ob_cnt_r + 2'(b2_valid_r) - 2'(o_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= '0;
    end else begin
      if (b2_valid_r) begin
        ob_wr_r <= ~ob_wr_r;
      end
      if (o_fire) begin
        ob_rd_r <= ~ob_rd_r;
      end
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_valid_r) begin
      ob_r[ob_wr_r] <= beat;
    end
  end

  assign out_chan.valid         = (ob_cnt_r != '0);
  assign out_chan.column        = ob_r[ob_rd_r].column;
  assign out_chan.added_level   = ob_r[ob_rd_r].added_level;
  assign out_chan.added_count   = ob_r[ob_rd_r].added_count;
  assign out_chan.removed_level = ob_r[ob_rd_r].removed_level;
  assign out_chan.removed_count = ob_r[ob_rd_r].removed_count;
  assign out_chan.last_in_frame = ob_r[ob_rd_r].last_in_frame;

endmodule

`default_nettype wire

### design/sliding_window_level_histogram_top.sv
// Sliding-window persistence histogram.
// in_chan carries one 17-bit Q1.16 sample per beat; samples fill frames of
// cfg_wr_data columns (written with cfg_wr_en while idle, 0 acts as 1).
// Each sample is quantized to a level, stored in a history ring of
// HISTORY_DEPTH frames, and the count for (column, level) is raised while
// the count for the level leaving the window is lowered.
// out_chan returns one beat per sample, in order: column, both levels, both
// counts after the update, and an end-of-frame flag.
// Throughput: one sample per cycle while out_chan does not stall and the
// reset sweep is done; the front end does the history ring access, the back
// end two count read-modify-writes per beat on two dual-read memories. A
// beat passes the front register, queue, back register and output buffer.
// Reset: a zeroing sweep runs over the history and count memories;
// in_chan.ready stays low until it ends.
// A stalled receiver fills a two-beat output buffer and a four-beat queue,
// then ready drops; no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_level_histogram_top import swlh_pkg::*; #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int HISTORY_DEPTH = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  swlh_in_if.sink               in_chan,
  swlh_out_if.source            out_chan
);

  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int HIST_AW = SLOT_W + COL_W;
  localparam int CNT_AW  = LEVEL_W + COL_W;
  localparam int CLR_W   = (HIST_AW > CNT_AW) ? HIST_AW : CNT_AW;
  localparam int ENTRY_W = COL_W + 2 * LEVEL_W + 1;

  logic               clr_busy_r;
  logic [CLR_W-1:0]   clr_addr_r;
  logic               q_push, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  logic [QCNT_W-1:0]  q_count;

  // zeroing sweep over the memories after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {CLR_W{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  swlh_front #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .COL_W         (COL_W),
    .CLR_W         (CLR_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .clr_busy    (clr_busy_r),
    .clr_addr    (clr_addr_r),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  swlh_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_rdata),
    .count      (q_count)
  );

  swlh_back #(
    .COL_W (COL_W),
    .CLR_W (CLR_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy_r),
    .clr_addr (clr_addr_r),
    .q_valid  (q_valid),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
